[rtl/lidar_packet_parser_scan_store_macros.svh]
// Assertion macros for the range sensor packet parser and scan store.
`ifndef LIDAR_PACKET_PARSER_SCAN_STORE_MACROS_SVH
`define LIDAR_PACKET_PARSER_SCAN_STORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define LPSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define LPSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lpss_pkg.sv]
// Shared types and constants for the range sensor packet parser and scan store.
package lpss_pkg;

    localparam int SCAN_ENTRIES = 360;
    localparam int BUFFER_COUNT = 2;
    localparam int TABLE_DEPTH  = SCAN_ENTRIES * BUFFER_COUNT;
    localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
    localparam int DIST_W       = 14;
    // Entry: distance, then one bit for nonzero strength.
    localparam int ENTRY_W      = DIST_W + 1;

    localparam logic [7:0]  START_BYTE   = 8'hFA;
    localparam logic [7:0]  INDEX_LOW    = 8'hA0;
    localparam logic [7:0]  INDEX_HIGH   = 8'hF9;
    localparam logic [8:0]  ANGLE_LIMIT  = 9'(SCAN_ENTRIES);
    localparam logic [TABLE_AW-1:0] HALF_OFFSET = TABLE_AW'(SCAN_ENTRIES);
    localparam logic [TABLE_AW-1:0] LAST_ENTRY  = TABLE_AW'(TABLE_DEPTH - 1);

    localparam logic [4:0] PH_START      = 5'd0;
    localparam logic [4:0] PH_INDEX      = 5'd1;
    localparam logic [4:0] PH_SPEED_LO   = 5'd2;
    localparam logic [4:0] PH_SPEED_HI   = 5'd3;
    localparam logic [4:0] PH_DATA_FIRST = 5'd4;
    localparam logic [4:0] PH_DATA_LAST  = 5'd19;
    localparam logic [4:0] PH_CK_LO      = 5'd20;
    localparam logic [4:0] PH_CK_HI      = 5'd21;

    localparam logic [1:0] SLOT_DIST_HI = 2'd1;
    localparam logic [1:0] SLOT_STR_HI  = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [8:0] angle;
    } in_t;

    typedef struct packed {
        logic [13:0] distance;
        logic        distance_valid;
        logic [9:0]  speed_rpm;
        logic        packet_done;
        logic        checksum_ok;
        logic        scan_done;
    } out_t;

    typedef struct packed {
        logic                en;
        logic [TABLE_AW-1:0] addr;
        logic [ENTRY_W-1:0]  data;
    } wr_req_t;

    typedef struct packed {
        logic packet_done;
        logic checksum_ok;
        logic scan_done;
    } pkt_status_t;

endpackage

[rtl/lidar_packet_parser_scan_store.sv]
// Top level: range sensor packet parser with double-buffered scan table.
//
// Each request is either one received sensor byte (mode 0) or a distance
// query by angle (mode 1). One request is taken per clock while the output
// side is not stalled, and each request yields exactly one response; the
// response passes the scan table's registered read port and then the output
// register. After reset the 720-entry scan table is cleared one entry per
// cycle, and s_ready stays low until the clear is done. Checksum status does
// not gate table writes.
`include "lidar_packet_parser_scan_store_macros.svh"

module lidar_packet_parser_scan_store (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lpss_pkg::in_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lpss_pkg::out_t m_data
);
    import lpss_pkg::*;

    logic                clearing_reg;
    logic [TABLE_AW-1:0] clr_cnt_reg;

    logic        accept;
    logic        s1_adv;
    wr_req_t     wr;
    pkt_status_t status;
    logic [9:0]  speed_rpm;
    logic        show_sel;

    logic                ram_we;
    logic [TABLE_AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [TABLE_AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic        s1_valid_reg;
    logic        s1_query_reg;
    logic [9:0]  s1_speed_reg;
    pkt_status_t s1_status_reg;

    logic        m_valid_reg;
    out_t        m_data_reg;
    out_t        result;
    logic        hit;

    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept  = s_valid && s_ready;

    lpss_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (accept && !s_data.mode),
        .rx_byte   (s_data.rx_byte),
        .wr        (wr),
        .status    (status),
        .speed_rpm (speed_rpm),
        .show_sel  (show_sel)
    );

    assign ram_we    = clearing_reg || wr.en;
    assign ram_waddr = clearing_reg ? clr_cnt_reg : wr.addr;
    assign ram_wdata = clearing_reg ? '0 : wr.data;
    assign ram_re    = accept && s_data.mode && (s_data.angle < ANGLE_LIMIT);
    assign ram_raddr = {1'b0, s_data.angle} + (show_sel ? HALF_OFFSET : '0);

    lpss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ENTRY) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (!s1_valid_reg || s1_adv) begin
            s1_valid_reg <= accept;
        end
        if (accept) begin
            s1_query_reg  <= ram_re;
            s1_speed_reg  <= speed_rpm;
            s1_status_reg <= status;
        end
    end

    assign hit = s1_query_reg && ram_rdata[0];

    always_comb begin
        result.distance       = hit ? ram_rdata[ENTRY_W-1:1] : '0;
        result.distance_valid = hit;
        result.speed_rpm      = s1_speed_reg;
        result.packet_done    = s1_status_reg.packet_done;
        result.checksum_ok    = s1_status_reg.checksum_ok;
        result.scan_done      = s1_status_reg.scan_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
        if (s1_adv && s1_valid_reg) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `LPSS_ASSERT_SAME(a_no_accept_while_clearing, clearing_reg, !s_ready,
        "request accepted during table clear")
    `LPSS_ASSERT_SAME(a_status_needs_packet_done, m_valid && !m_data.packet_done,
        !m_data.checksum_ok && !m_data.scan_done, "checksum or scan status without packet end")
    `LPSS_ASSERT_SAME(a_invalid_distance_zero, m_valid && !m_data.distance_valid,
        m_data.distance == '0, "nonzero distance on invalid response")
    `LPSS_ASSERT_NEXT(a_stage_holds_on_stall, s1_valid_reg && !s1_adv, s1_valid_reg,
        "pending response dropped under backpressure")

endmodule

[rtl/lpss_ram.sv]
// Generic simple dual-port RAM with registered read.
module lpss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lpss_parser.sv]
// Packet parser: word pairing, checksum, speed and table write requests.
module lpss_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           rx_byte,
    output lpss_pkg::wr_req_t    wr,
    output lpss_pkg::pkt_status_t status,
    output logic [9:0]           speed_rpm,
    output logic                 show_sel
);
    import lpss_pkg::*;

    logic [4:0]  phase_reg,   phase_next;
    logic [29:0] acc_reg,     acc_next;
    logic [15:0] word_reg,    word_next;
    logic        expect_reg,  expect_next;
    logic [8:0]  angle_reg,   angle_next;
    logic [9:0]  speed_reg,   speed_next;
    logic [15:0] pending_reg, pending_next;
    logic        fill_reg,    fill_next;
    logic        show_reg,    show_next;

    logic [14:0] fold;
    logic [7:0]  idx;
    logic        flagged;
    logic [15:0] dist_clean;

    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        word_next    = word_reg;
        expect_next  = expect_reg;
        angle_next   = angle_reg;
        speed_next   = speed_reg;
        pending_next = pending_reg;
        fill_next    = fill_reg;
        show_next    = show_reg;
        status       = '0;
        wr           = '0;
        fold         = '0;
        idx          = rx_byte - INDEX_LOW;
        flagged      = pending_reg[15] | pending_reg[14];
        dist_clean   = flagged ? 16'h0000 : pending_reg;

        if (byte_en) begin
            if (expect_reg) begin
                word_next = {8'h00, rx_byte};
            end else begin
                word_next = word_reg | {rx_byte, 8'h00};
                if (phase_reg != PH_CK_LO && phase_reg != PH_CK_HI) begin
                    acc_next = (acc_reg << 1) + {14'h0000, word_next};
                end
            end
            expect_next = !expect_reg;
            fold = acc_next[14:0] + acc_next[29:15];

            unique case (phase_reg)
                PH_START: begin
                    if (rx_byte == START_BYTE) begin
                        acc_next    = '0;
                        word_next   = {8'h00, rx_byte};
                        expect_next = 1'b0;
                        phase_next  = PH_INDEX;
                    end
                end
                PH_INDEX: begin
                    if (rx_byte >= INDEX_LOW && rx_byte <= INDEX_HIGH) begin
                        angle_next = {idx[6:0], 2'b00};
                        phase_next = PH_SPEED_LO;
                    end else begin
                        phase_next = PH_START;
                    end
                end
                PH_SPEED_LO: begin
                    phase_next = PH_SPEED_HI;
                end
                PH_SPEED_HI: begin
                    speed_next = word_next[15:6];
                    phase_next = PH_DATA_FIRST;
                end
                PH_CK_LO: begin
                    phase_next = PH_CK_HI;
                end
                PH_CK_HI: begin
                    status.packet_done = 1'b1;
                    status.checksum_ok = ({1'b0, fold} == word_next);
                    if (angle_reg == ANGLE_LIMIT) begin
                        show_next        = fill_reg;
                        fill_next        = !fill_reg;
                        status.scan_done = 1'b1;
                    end
                    phase_next = PH_START;
                end
                default: begin
                    if (phase_reg >= PH_DATA_FIRST && phase_reg <= PH_DATA_LAST) begin
                        if (phase_reg[1:0] == SLOT_DIST_HI) begin
                            pending_next = word_next;
                        end else if (phase_reg[1:0] == SLOT_STR_HI) begin
                            wr.en   = (angle_reg < ANGLE_LIMIT);
                            wr.addr = {1'b0, angle_reg} + (fill_reg ? HALF_OFFSET : '0);
                            wr.data = {dist_clean[13:0],
                                       (!flagged) && (word_next != 16'h0000)};
                            pending_next = dist_clean;
                            angle_next   = angle_reg + 9'd1;
                        end
                        phase_next = phase_reg + 5'd1;
                    end else begin
                        phase_next = PH_START;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            acc_reg     <= '0;
            word_reg    <= '0;
            expect_reg  <= 1'b1;
            angle_reg   <= '0;
            speed_reg   <= '0;
            pending_reg <= '0;
            fill_reg    <= 1'b0;
            show_reg    <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            word_reg    <= word_next;
            expect_reg  <= expect_next;
            angle_reg   <= angle_next;
            speed_reg   <= speed_next;
            pending_reg <= pending_next;
            fill_reg    <= fill_next;
            show_reg    <= show_next;
        end
    end

    assign speed_rpm = speed_next;
    assign show_sel  = show_reg;

endmodule

[tb/tb_lidar_packet_parser_scan_store.sv]
// Testbench for the range sensor packet parser and scan store: random packets and queries.
module tb_lidar_packet_parser_scan_store;
    import lpss_pkg::*;

    localparam int          N_ITEMS      = 1900;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [15:0] FLAG_MASK    = 16'hC000;
    localparam logic [31:0] FOLD_MASK    = 32'h0000_7FFF;

    class scan_store_scoreboard;
        out_t        expected_q[$];
        logic [4:0]  phase;
        logic [31:0] ck_accum;
        logic [15:0] word_buf;
        logic        low_next;
        logic [8:0]  wr_angle;
        logic [15:0] speed_word;
        logic [15:0] dist_hold;
        logic        fill_sel;
        logic        show_sel;
        logic [13:0] dist_mem [SCAN_ENTRIES*BUFFER_COUNT];
        logic [15:0] str_mem [SCAN_ENTRIES*BUFFER_COUNT];
        int          errors;
        int          queries;
        int          hits;
        int          packets;
        int          ck_matches;
        int          scans;

        function new();
            phase      = PH_START;
            ck_accum   = '0;
            word_buf   = '0;
            low_next   = 1'b1;
            wr_angle   = '0;
            speed_word = '0;
            dist_hold  = '0;
            fill_sel   = 1'b0;
            show_sel   = 1'b0;
            for (int i = 0; i < SCAN_ENTRIES * BUFFER_COUNT; i++) begin
                dist_mem[i] = '0;
                str_mem[i]  = '0;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Flagged readings land in the table as zero distance and zero strength.
        function void store_pair(logic [15:0] strength);
            logic [15:0] d;
            logic [15:0] s;
            int          idx;
            d = dist_hold;
            s = strength;
            if ((d & FLAG_MASK) != 0) begin
                d = '0;
                s = '0;
            end
            if (wr_angle < SCAN_ENTRIES) begin
                idx = (fill_sel ? SCAN_ENTRIES : 0) + int'(wr_angle);
                dist_mem[idx] = d[13:0];
                str_mem[idx]  = s;
            end
            dist_hold = d;
            wr_angle  = wr_angle + 9'd1;
        endfunction

        function void note_request(in_t req);
            out_t        res;
            logic [31:0] fold;
            logic [4:0]  slot;
            int          idx;
            res = '0;
            if (req.mode) begin
                queries++;
                if (req.angle < SCAN_ENTRIES) begin
                    idx = (show_sel ? SCAN_ENTRIES : 0) + int'(req.angle);
                    if (str_mem[idx] != 0) begin
                        res.distance       = dist_mem[idx];
                        res.distance_valid = 1'b1;
                        hits++;
                    end
                end
            end else begin
                if (low_next) begin
                    word_buf = {8'h00, req.rx_byte};
                end else begin
                    word_buf = word_buf | {req.rx_byte, 8'h00};
                    if (phase != PH_CK_LO && phase != PH_CK_HI)
                        ck_accum = (ck_accum << 1) + 32'(word_buf);
                end
                low_next = !low_next;

                if (phase == PH_START) begin
                    if (req.rx_byte == START_BYTE) begin
                        ck_accum = '0;
                        word_buf = {8'h00, req.rx_byte};
                        low_next = 1'b0;
                        phase    = PH_INDEX;
                    end
                end else if (phase == PH_INDEX) begin
                    if (req.rx_byte >= INDEX_LOW && req.rx_byte <= INDEX_HIGH) begin
                        wr_angle = 9'(req.rx_byte - INDEX_LOW) << 2;
                        phase    = PH_SPEED_LO;
                    end else begin
                        phase = PH_START;
                    end
                end else if (phase == PH_SPEED_LO) begin
                    phase = PH_SPEED_HI;
                end else if (phase == PH_SPEED_HI) begin
                    speed_word = word_buf;
                    phase      = PH_DATA_FIRST;
                end else if (phase >= PH_DATA_FIRST && phase <= PH_DATA_LAST) begin
                    slot = phase - PH_DATA_FIRST;
                    if (slot[1:0] == SLOT_DIST_HI)
                        dist_hold = word_buf;
                    else if (slot[1:0] == SLOT_STR_HI)
                        store_pair(word_buf);
                    phase = phase + 5'd1;
                end else if (phase == PH_CK_LO) begin
                    phase = PH_CK_HI;
                end else if (phase == PH_CK_HI) begin
                    fold = (ck_accum + (ck_accum >> 15)) & FOLD_MASK;
                    res.packet_done = 1'b1;
                    res.checksum_ok = (fold == 32'(word_buf));
                    packets++;
                    if (res.checksum_ok)
                        ck_matches++;
                    if (wr_angle == SCAN_ENTRIES) begin
                        show_sel      = fill_sel;
                        fill_sel      = !fill_sel;
                        res.scan_done = 1'b1;
                        scans++;
                    end
                    phase = PH_START;
                end else begin
                    phase = PH_START;
                end
            end
            res.speed_rpm = speed_word[15:6];
            expected_q.push_back(res);
        endfunction

        function void field_check(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(out_t got);
            out_t want;
            if (expected_q.size() == 0) begin
                $error("response 0x%h arrived with no request outstanding", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            field_check("distance", want.distance, got.distance);
            field_check("distance_valid", want.distance_valid, got.distance_valid);
            field_check("speed_rpm", want.speed_rpm, got.speed_rpm);
            field_check("packet_done", want.packet_done, got.packet_done);
            field_check("checksum_ok", want.checksum_ok, got.checksum_ok);
            field_check("scan_done", want.scan_done, got.scan_done);
        endfunction
    endclass

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    in_t    s_data  = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    out_t   m_data;

    bit     idling  = 1'b0;
    int     sent    = 0;
    int     ready_hold  = 0;
    int     cycle_count = 0;
    scan_store_scoreboard sb;

    lidar_packet_parser_scan_store u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timed out after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Responses are checked before the same edge's request is noted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_response(m_data);
            if (s_valid && s_ready)
                sb.note_request(s_data);
        end
    end

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 11);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_request(input in_t req);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_t req;
        req.mode    = 1'b0;
        req.rx_byte = b;
        req.angle   = 9'($urandom);
        push_request(req);
    endtask

    task automatic send_query(input logic [8:0] a);
        in_t req;
        req.mode    = 1'b1;
        req.rx_byte = 8'($urandom);
        req.angle   = a;
        push_request(req);
    endtask

    function automatic logic [8:0] pick_angle();
        if ($urandom_range(0, 7) == 0)
            return 9'($urandom_range(SCAN_ENTRIES, 511));
        return 9'($urandom_range(0, SCAN_ENTRIES - 1));
    endfunction

    // pairs holds distance, strength, distance, strength, ...
    task automatic send_packet(input logic [7:0] idx, input logic [15:0] speed,
                               input logic [7:0][15:0] pairs, input bit corrupt,
                               input bit mixed);
        logic [9:0][15:0] words;
        logic [31:0]      acc;
        logic [15:0]      ck;
        words[0] = {idx, START_BYTE};
        words[1] = speed;
        for (int i = 0; i < 8; i++)
            words[i + 2] = pairs[i];
        acc = '0;
        for (int i = 0; i < 10; i++)
            acc = (acc << 1) + 32'(words[i]);
        ck = 16'((acc + (acc >> 15)) & FOLD_MASK);
        if (corrupt)
            ck = ck ^ (16'd1 << $urandom_range(0, 15));
        for (int i = 0; i < 10; i++) begin
            send_byte(words[i][7:0]);
            if (mixed && $urandom_range(0, 5) == 0)
                send_query(pick_angle());
            send_byte(words[i][15:8]);
            if (mixed && $urandom_range(0, 5) == 0)
                send_query(pick_angle());
        end
        send_byte(ck[7:0]);
        send_byte(ck[15:8]);
    endtask

    initial begin
        logic [7:0][15:0] pairs;
        logic [7:0]       idx;
        int               pick;
        int               r;
        bit               paused;
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        idling = 1'b1;

        // Empty table, then one packet closing a scan with clean, flagged and
        // zero-strength readings, then queries around the top of the range.
        send_query(9'd511);
        pairs[0] = 16'h3FFF;
        pairs[1] = 16'hFFFF;
        pairs[2] = 16'h8123;
        pairs[3] = 16'h0055;
        pairs[4] = 16'h4321;
        pairs[5] = 16'h0077;
        pairs[6] = 16'h0ABC;
        pairs[7] = 16'h0000;
        send_packet(INDEX_HIGH, 16'hFFFF, pairs, 1'b0, 1'b0);
        send_query(9'd356);
        send_query(9'd359);
        send_query(9'd360);

        paused = 1'b0;
        while (sent < N_ITEMS) begin
            idling = (sent < 500) || (sent >= 800 && sent < 1500);
            if (!paused && sent >= N_ITEMS / 2) begin
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
                @(negedge aclk);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                for (int i = 0; i < 4; i++) begin
                    r = $urandom_range(0, 7);
                    pairs[2*i]     = {(r == 0 || r == 2), (r == 1 || r == 2), 14'($urandom)};
                    pairs[2*i + 1] = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
                end
                idx = ($urandom_range(0, 4) == 0) ? INDEX_HIGH
                                                  : 8'($urandom_range(INDEX_LOW, INDEX_HIGH));
                send_packet(idx, 16'($urandom), pairs, $urandom_range(0, 7) == 0,
                            1'($urandom));
            end else if (pick < 78) begin
                send_byte(START_BYTE);
                if ($urandom_range(0, 1) == 1)
                    send_byte(8'($urandom_range(0, INDEX_LOW - 1)));
                else
                    send_byte(8'($urandom_range(INDEX_HIGH + 1, 255)));
            end else if (pick < 84) begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) send_query(pick_angle());
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: %0d distance queries, %0d of them on stored readings.",
                 sent, sb.queries, sb.hits);
        $display("Parsed %0d complete packets, %0d with good checksum, %0d scan swaps.",
                 sb.packets, sb.ck_matches, sb.scans);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
